// ----- hw/rtl/blm_pkg.sv -----
// ----------------------------------------------------------------------------
// blm_pkg: shared types, constants and Q24.40 helpers for the minimizer
// Holds the fixed-point type, saturating arithmetic and the control codes.
// ----------------------------------------------------------------------------
package blm_pkg;

    typedef logic signed [63:0] fix_t;

    localparam fix_t FIX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam fix_t FIX_MIN  = 64'sh8000_0000_0000_0000;
    localparam fix_t GOLD_Q40 = 64'sd419976070785;

    localparam fix_t       RST_LOWER = 64'sd0;
    localparam fix_t       RST_UPPER = 64'sd1099511627776;
    localparam logic [31:0] RST_REL  = 32'd28147;
    localparam logic [62:0] RST_ABS  = 63'd1099512;

    typedef enum logic [1:0] {
        REG_LOWER = 2'd0,
        REG_UPPER = 2'd1,
        REG_REL   = 2'd2,
        REG_ABS   = 2'd3
    } reg_idx_t;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_VALUE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIRST = 2'd1,
        PH_RUN   = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    // One queued item as the sequencer sees it.
    typedef struct packed {
        logic  valid;
        kind_t kind;
        fix_t  point;
        fix_t  value;
    } item_t;

    typedef struct packed {
        logic        done;
        fix_t        prod;
        logic [63:0] raw48;
        logic        over48;
    } mul_rsp_t;

    typedef struct packed {
        logic done;
        fix_t quo;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START_MUL, ST_START_SET, ST_UPDATE, ST_TOL, ST_T2, ST_CHECK,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
        ST_C1, ST_C2, ST_C3, ST_C4, ST_DIV, ST_U1, ST_U2,
        ST_G1, ST_G2, ST_FIN, ST_EMIT
    } state_t;

    function automatic fix_t sadd(fix_t a, fix_t b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? FIX_MIN : FIX_MAX;
        return s[63:0];
    endfunction

    function automatic fix_t ssub(fix_t a, fix_t b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? FIX_MIN : FIX_MAX;
        return s[63:0];
    endfunction

    function automatic fix_t sneg(fix_t a);
        return ssub(64'sd0, a);
    endfunction

    function automatic fix_t sabs(fix_t a);
        return a[63] ? sneg(a) : a;
    endfunction

    function automatic fix_t half_floor(fix_t a);
        return a >>> 1;
    endfunction

    function automatic logic [63:0] mag(fix_t a);
        return a[63] ? (64'd0 - 64'(a)) : 64'(a);
    endfunction

    // Attach a sign to a magnitude and clamp to the signed range.
    function automatic fix_t signed_sat(logic [63:0] m, logic neg, logic over);
        if (neg) begin
            if (over || m > 64'h8000_0000_0000_0000) return FIX_MIN;
            return fix_t'(64'd0 - m);
        end
        if (over || m[63]) return FIX_MAX;
        return fix_t'(m);
    endfunction

endpackage

// ----- hw/rtl/blm_front.sv -----
// ----------------------------------------------------------------------------
// blm_front: input side of the minimizer
// Takes items from the stream, tags them as start or value, and holds them
// in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module blm_front
    import blm_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  logic  s_command,
    input  fix_t  s_point,
    input  fix_t  s_value,
    input  logic  pop,
    output item_t head
);

    item_t      ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       do_pop;
    kind_t      kind;

    assign kind     = s_command ? KIND_VALUE : KIND_START;
    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign do_pop   = pop && (count_reg != 2'd0);

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_comb begin
        head       = ent_reg[rd_ptr_reg];
        head.valid = (count_reg != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= '{valid: 1'b1, kind: kind, point: s_point, value: s_value};
        end
    end

endmodule

// ----- hw/rtl/blm_mul.sv -----
// ----------------------------------------------------------------------------
// blm_mul: iterative signed Q24.40 multiplier
// Builds the 128-bit magnitude product from four 32x32 partial products and
// returns it truncated at bit 40 (saturated) and at bit 48 (raw).
// ----------------------------------------------------------------------------
module blm_mul
    import blm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  fix_t     op_a,
    input  fix_t     op_b,
    output mul_rsp_t rsp
);

    logic [63:0]  am_reg, bm_reg;
    logic         neg_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic [63:0]  pp_reg;
    logic [127:0] acc_reg;
    logic [31:0]  mul_x, mul_y;
    logic [127:0] acc_add;
    logic [1:0]   prev_idx;

    assign prev_idx = 2'(cnt_reg - 3'd1);

    always_comb begin
        mul_x = cnt_reg[1] ? am_reg[63:32] : am_reg[31:0];
        mul_y = cnt_reg[0] ? bm_reg[63:32] : bm_reg[31:0];
        case (prev_idx)
            2'd0:    acc_add = {64'd0, pp_reg};
            2'd3:    acc_add = {pp_reg, 64'd0};
            default: acc_add = {32'd0, pp_reg, 32'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rsp.done <= 1'b0;
        end else begin
            rsp.done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                am_reg   <= mag(op_a);
                bm_reg   <= mag(op_b);
                neg_reg  <= op_a[63] != op_b[63];
                cnt_reg  <= 3'd0;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg < 3'd4) pp_reg <= mul_x * mul_y;
                if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4) acc_reg <= acc_reg + acc_add;
                if (cnt_reg == 3'd5) begin
                    busy_reg   <= 1'b0;
                    rsp.done   <= 1'b1;
                    rsp.prod   <= signed_sat(acc_reg[103:40], neg_reg, |acc_reg[127:104]);
                    rsp.raw48  <= acc_reg[111:48];
                    rsp.over48 <= |acc_reg[127:112];
                end
            end
        end
    end

endmodule

// ----- hw/rtl/blm_div.sv -----
// ----------------------------------------------------------------------------
// blm_div: radix-2 restoring divider for Q24.40 quotients
// Produces p/q truncated toward zero and saturated, one bit per cycle.
// ----------------------------------------------------------------------------
module blm_div
    import blm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  fix_t     num,
    input  fix_t     den,
    output div_rsp_t rsp
);

    logic [63:0] hi_reg, lo_reg, quo_reg, den_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [63:0] n_mag, d_mag, shifted;
    logic        take;
    logic [63:0] quo_step;

    assign n_mag    = mag(num);
    assign d_mag    = mag(den);
    assign shifted  = {hi_reg[62:0], lo_reg[63]};
    assign take     = hi_reg[63] || (shifted >= den_reg);
    assign quo_step = {quo_reg[62:0], take};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rsp.done <= 1'b0;
        end else begin
            rsp.done <= 1'b0;
            if (start) begin
                if (d_mag == 64'd0 || {24'd0, n_mag[63:24]} >= d_mag) rsp.done <= 1'b1;
                else busy_reg <= 1'b1;
                hi_reg  <= {24'd0, n_mag[63:24]};
                lo_reg  <= {n_mag[23:0], 40'd0};
                den_reg <= d_mag;
                quo_reg <= '0;
                neg_reg <= num[63] != den[63];
                cnt_reg <= 6'd0;
                if (d_mag == 64'd0) begin
                    rsp.quo <= (n_mag == 64'd0) ? 64'sd0 : (num[63] ? FIX_MIN : FIX_MAX);
                end else begin
                    rsp.quo <= signed_sat(64'd0, num[63] != den[63], 1'b1);
                end
            end else if (busy_reg) begin
                hi_reg  <= take ? shifted - den_reg : shifted;
                lo_reg  <= {lo_reg[62:0], 1'b0};
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    rsp.done <= 1'b1;
                    rsp.quo  <= signed_sat(quo_step, neg_reg, 1'b0);
                end
            end
        end
    end

endmodule

// ----- hw/rtl/blm_back.sv -----
// ----------------------------------------------------------------------------
// blm_back: search sequencer of the minimizer
// Runs the bracket update, stopping test and parabolic or golden step for
// each value item of a search, using the shared multiplier and the divider.
// ----------------------------------------------------------------------------
module blm_back
    import blm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  item_t       head,
    output logic        pop,
    input  fix_t        lower_bound,
    input  fix_t        upper_bound,
    input  logic [31:0] rel_tolerance,
    input  logic [62:0] abs_tolerance,
    output logic        m_valid,
    input  logic        m_ready,
    output fix_t        next_point,
    output logic        done_res,
    output fix_t        best_point,
    output fix_t        best_value
);

    state_t state_reg, state_next;
    phase_t phase_reg;
    fix_t   a_reg, b_reg, x_reg, w_reg, v_reg, fx_reg, fw_reg, fv_reg;
    fix_t   e_reg, d_reg, u_reg;
    fix_t   pt_reg, val_reg;
    fix_t   m_reg, tol_reg, t2_reg, h_reg, p_reg, q_reg, r_reg, tmp_reg;
    fix_t   c1_reg, c2_reg, c3_reg;
    logic   out_valid_reg;
    logic   mul_wait_reg, div_wait_reg;

    logic     mul_state, mul_start, div_start;
    fix_t     mul_a, mul_b;
    mul_rsp_t mul_rsp;
    div_rsp_t div_rsp;

    logic        stop_hit, para_ok, near_edge;
    fix_t        qq;
    logic [64:0] tol_sum;
    fix_t        d_adj;

    blm_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .rsp(mul_rsp)
    );

    blm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(p_reg), .den(q_reg), .rsp(div_rsp)
    );

    assign stop_hit  = sabs(ssub(x_reg, m_reg)) <= ssub(t2_reg, h_reg);
    assign para_ok   = (sabs(p_reg) < c1_reg) && (p_reg > c2_reg) && (p_reg < c3_reg);
    assign near_edge = (ssub(u_reg, a_reg) < t2_reg) || (ssub(b_reg, u_reg) < t2_reg);
    assign qq        = sadd(q_reg, q_reg);
    assign tol_sum   = {1'b0, mul_rsp.raw48} + {2'b00, abs_tolerance};
    assign d_adj     = (sabs(d_reg) >= tol_reg) ? d_reg
                     : ((d_reg > 64'sd0) ? tol_reg : sneg(tol_reg));

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_state = 1'b1;
        mul_a     = GOLD_Q40;
        mul_b     = e_reg;
        unique case (state_reg)
            ST_START_MUL: mul_b = ssub(upper_bound, lower_bound);
            ST_TOL: begin
                mul_a = fix_t'({32'd0, rel_tolerance});
                mul_b = x_reg;
            end
            ST_P1: begin
                mul_a = ssub(x_reg, w_reg);
                mul_b = ssub(fx_reg, fv_reg);
            end
            ST_P2: begin
                mul_a = ssub(x_reg, v_reg);
                mul_b = ssub(fx_reg, fw_reg);
            end
            ST_P3: begin
                mul_a = ssub(x_reg, v_reg);
                mul_b = q_reg;
            end
            ST_P4: begin
                mul_a = ssub(x_reg, w_reg);
                mul_b = r_reg;
            end
            ST_C1: begin
                mul_a = q_reg;
                mul_b = r_reg;
            end
            ST_C2: begin
                mul_a = q_reg;
                mul_b = ssub(a_reg, x_reg);
            end
            ST_C3: begin
                mul_a = q_reg;
                mul_b = ssub(b_reg, x_reg);
            end
            ST_G2: ;
            default: mul_state = 1'b0;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        mul_start = mul_state && !mul_wait_reg;
        div_start = (state_reg == ST_DIV) && !div_wait_reg;
        pop       = (state_reg == ST_IDLE) && head.valid;
    end

    // Next-state decode.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    if (head.kind == KIND_START) state_next = ST_START_MUL;
                    else if (phase_reg == PH_DONE) state_next = ST_EMIT;
                    else if (phase_reg != PH_IDLE) state_next = ST_UPDATE;
                end
            end
            ST_START_MUL: if (mul_rsp.done) state_next = ST_START_SET;
            ST_START_SET: state_next = ST_EMIT;
            ST_UPDATE:    state_next = ST_TOL;
            ST_TOL:       if (mul_rsp.done) state_next = ST_T2;
            ST_T2:        state_next = ST_CHECK;
            ST_CHECK: begin
                if (stop_hit) state_next = ST_EMIT;
                else if (sabs(e_reg) > tol_reg) state_next = ST_P1;
                else state_next = ST_C1;
            end
            ST_P1: if (mul_rsp.done) state_next = ST_P2;
            ST_P2: if (mul_rsp.done) state_next = ST_P3;
            ST_P3: if (mul_rsp.done) state_next = ST_P4;
            ST_P4: if (mul_rsp.done) state_next = ST_P5;
            ST_P5: state_next = ST_P6;
            ST_P6: state_next = ST_C1;
            ST_C1: if (mul_rsp.done) state_next = ST_C2;
            ST_C2: if (mul_rsp.done) state_next = ST_C3;
            ST_C3: if (mul_rsp.done) state_next = ST_C4;
            ST_C4: state_next = para_ok ? ST_DIV : ST_G1;
            ST_DIV: if (div_rsp.done) state_next = ST_U1;
            ST_U1: state_next = ST_U2;
            ST_U2: state_next = ST_FIN;
            ST_G1: state_next = ST_G2;
            ST_G2: if (mul_rsp.done) state_next = ST_FIN;
            ST_FIN: state_next = ST_EMIT;
            ST_EMIT: if (!out_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
            mul_wait_reg  <= 1'b0;
            div_wait_reg  <= 1'b0;
            a_reg  <= '0; b_reg  <= '0; x_reg <= '0; w_reg <= '0; v_reg <= '0;
            fx_reg <= '0; fw_reg <= '0; fv_reg <= '0;
            e_reg  <= '0; d_reg  <= '0; u_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (mul_start) mul_wait_reg <= 1'b1;
            else if (mul_rsp.done) mul_wait_reg <= 1'b0;
            if (div_start) div_wait_reg <= 1'b1;
            else if (div_rsp.done) div_wait_reg <= 1'b0;
            if (state_reg == ST_EMIT && (!out_valid_reg || m_ready)) out_valid_reg <= 1'b1;
            else if (m_valid && m_ready) out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    pt_reg  <= head.point;
                    val_reg <= head.value;
                end
                ST_START_MUL: if (mul_rsp.done) tmp_reg <= mul_rsp.prod;
                ST_START_SET: begin
                    a_reg  <= lower_bound;
                    b_reg  <= upper_bound;
                    x_reg  <= sadd(lower_bound, tmp_reg);
                    w_reg  <= sadd(lower_bound, tmp_reg);
                    v_reg  <= sadd(lower_bound, tmp_reg);
                    u_reg  <= sadd(lower_bound, tmp_reg);
                    fx_reg <= '0; fw_reg <= '0; fv_reg <= '0;
                    e_reg  <= '0; d_reg  <= '0;
                    phase_reg <= PH_FIRST;
                end
                ST_UPDATE: begin
                    if (phase_reg == PH_FIRST) begin
                        x_reg <= pt_reg; w_reg <= pt_reg; v_reg <= pt_reg;
                        fx_reg <= val_reg; fw_reg <= val_reg; fv_reg <= val_reg;
                    end else if (val_reg <= fx_reg) begin
                        if (pt_reg < x_reg) b_reg <= x_reg;
                        else a_reg <= x_reg;
                        v_reg <= w_reg; fv_reg <= fw_reg;
                        w_reg <= x_reg; fw_reg <= fx_reg;
                        x_reg <= pt_reg; fx_reg <= val_reg;
                    end else begin
                        if (pt_reg < x_reg) a_reg <= pt_reg;
                        else b_reg <= pt_reg;
                        if (val_reg <= fw_reg || w_reg == x_reg) begin
                            v_reg <= w_reg; fv_reg <= fw_reg;
                            w_reg <= pt_reg; fw_reg <= val_reg;
                        end else begin
                            v_reg <= pt_reg; fv_reg <= val_reg;
                        end
                    end
                end
                ST_TOL: begin
                    m_reg <= half_floor(a_reg) + half_floor(b_reg)
                           + fix_t'({63'd0, a_reg[0] & b_reg[0]});
                    if (mul_rsp.done) begin
                        tol_reg <= (mul_rsp.over48 || tol_sum[64] || tol_sum[63])
                                 ? FIX_MAX : fix_t'(tol_sum[63:0]);
                    end
                end
                ST_T2: begin
                    t2_reg <= sadd(tol_reg, tol_reg);
                    h_reg  <= half_floor(ssub(b_reg, a_reg));
                end
                ST_CHECK: begin
                    p_reg <= '0; q_reg <= '0; r_reg <= '0;
                    if (stop_hit) phase_reg <= PH_DONE;
                end
                ST_P1: if (mul_rsp.done) r_reg <= mul_rsp.prod;
                ST_P2: if (mul_rsp.done) q_reg <= mul_rsp.prod;
                ST_P3: if (mul_rsp.done) tmp_reg <= mul_rsp.prod;
                ST_P4: if (mul_rsp.done) p_reg <= ssub(tmp_reg, mul_rsp.prod);
                ST_P5: q_reg <= ssub(q_reg, r_reg);
                ST_P6: begin
                    if (qq > 64'sd0) begin
                        q_reg <= qq;
                        p_reg <= sneg(p_reg);
                    end else begin
                        q_reg <= sneg(qq);
                    end
                    r_reg <= e_reg;
                    e_reg <= d_reg;
                end
                ST_C1: if (mul_rsp.done) c1_reg <= sabs(half_floor(mul_rsp.prod));
                ST_C2: if (mul_rsp.done) c2_reg <= mul_rsp.prod;
                ST_C3: if (mul_rsp.done) c3_reg <= mul_rsp.prod;
                ST_DIV: if (div_rsp.done) d_reg <= div_rsp.quo;
                ST_U1: u_reg <= sadd(x_reg, d_reg);
                ST_U2: begin
                    if (near_edge) d_reg <= (x_reg < m_reg) ? tol_reg : sneg(tol_reg);
                end
                ST_G1: e_reg <= ssub((x_reg < m_reg) ? b_reg : a_reg, x_reg);
                ST_G2: if (mul_rsp.done) d_reg <= mul_rsp.prod;
                ST_FIN: begin
                    u_reg     <= sadd(x_reg, d_adj);
                    phase_reg <= PH_RUN;
                end
                ST_EMIT: begin
                    if (!out_valid_reg || m_ready) begin
                        next_point    <= (phase_reg == PH_DONE) ? 64'sd0 : u_reg;
                        done_res      <= (phase_reg == PH_DONE);
                        best_point    <= x_reg;
                        best_value    <= fx_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = out_valid_reg;

    a_one_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_start && div_start))
        else $error("multiplier and divider started together");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && done_res |-> next_point == 64'sd0)
        else $error("done result carries a nonzero next point");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg != ST_IDLE || $past(head.kind) == KIND_VALUE)
        else $error("start item popped without leaving idle");

endmodule

// ----- hw/rtl/brent_local_minimizer_top.sv -----
// ----------------------------------------------------------------------------
// brent_local_minimizer_top: derivative-free 1-D minimizer engine
// Holds the configuration registers and joins the input queue, the search
// sequencer and its arithmetic units to the two stream channels.
// ----------------------------------------------------------------------------
// Use: write lower_bound, upper_bound, rel_tolerance and abs_tolerance on the
// configuration port while the block is idle. Send a start item (tuser 0) to
// begin a search: the block answers with the first point to evaluate. Every
// value item (tuser 1, tdata = point and f(point)) is answered with one item
// carrying the next point, the best point and its value; once the stopping
// test holds, the answer has done set, and later value items repeat it.
// Value items sent before any start are dropped without an answer.
// When the stopping test does not hold, the next point comes from a
// golden-section step, or from a parabolic fit that is tried and, if
// accepted, runs the bit-serial divider; the shared multiplier forms every
// product. Items are handled one at a time.
// A two-entry input queue takes items while the sequencer works, and the
// result register lets the sequencer finish the next item while an answer
// is still waiting. When the receiver stalls, the answer holds and the
// sequencer waits in its emit step. Reset restores the register defaults,
// empties the queue and returns the search to idle.
// ----------------------------------------------------------------------------
module brent_local_minimizer_top
    import blm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_wdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // point [63:0], value [127:64]
    input  logic          s_tuser,   // command [0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [191:0]  m_tdata,   // next_point [63:0], best_point [127:64],
                                     // best_value [191:128]
    output logic          m_tuser    // done_res [0]
);

    fix_t        lower_reg, upper_reg;
    logic [31:0] rel_reg;
    logic [62:0] abs_reg;
    item_t       head;
    logic        pop;
    fix_t        next_point, best_point, best_value;

    // Configuration registers, written in place with no handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= RST_LOWER;
            upper_reg <= RST_UPPER;
            rel_reg   <= RST_REL;
            abs_reg   <= RST_ABS;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_LOWER: lower_reg <= fix_t'(cfg_wdata);
                REG_UPPER: upper_reg <= fix_t'(cfg_wdata);
                REG_REL:   rel_reg   <= cfg_wdata[31:0];
                REG_ABS:   abs_reg   <= cfg_wdata[62:0];
                default: ;
            endcase
        end
    end

    blm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_command(s_tuser),
        .s_point(fix_t'(s_tdata[63:0])), .s_value(fix_t'(s_tdata[127:64])),
        .pop(pop), .head(head)
    );

    blm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .head(head), .pop(pop),
        .lower_bound(lower_reg), .upper_bound(upper_reg),
        .rel_tolerance(rel_reg), .abs_tolerance(abs_reg),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .next_point(next_point), .done_res(m_tuser),
        .best_point(best_point), .best_value(best_value)
    );

    assign m_tdata = {best_value, best_point, next_point};

endmodule
